[hw/rtl/subresource_range_splitter_top_macros.svh]
// assertion macros for the subresource range splitter
`ifndef SUBRESOURCE_RANGE_SPLITTER_TOP_MACROS_SVH
`define SUBRESOURCE_RANGE_SPLITTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define SSPLIT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssplit check failed");

// next-cycle implication, checked outside reset
`define SSPLIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssplit check failed");

`else

`define SSPLIT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SSPLIT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/ssplit_pkg.sv]
// shared types, widths and the axis cut function of the range splitter
package ssplit_pkg;

  localparam int LAYER_BITS = 11;
  localparam int MIP_BITS   = 4;
  localparam int MAX_PIECES = 5;
  localparam int ASPECT_W   = 4;

  // common axis width and derived arithmetic widths
  localparam int CW     = (LAYER_BITS > MIP_BITS) ? LAYER_BITS : MIP_BITS;
  localparam int CNT_W  = CW + 1;
  localparam int SUM_W  = CW + 2;
  localparam int DIF_W  = CW + 3;
  localparam int END_W  = CW + 3;
  localparam int PNUM_W = $clog2(MAX_PIECES);

  localparam logic [PNUM_W-1:0] LAST_NUM = PNUM_W'(MAX_PIECES - 1);

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef struct packed {
    logic [ASPECT_W-1:0]   target_aspect;
    logic [LAYER_BITS-1:0] target_base_layer;
    logic [LAYER_BITS:0]   target_layer_count;
    logic [MIP_BITS-1:0]   target_base_mip;
    logic [MIP_BITS:0]     target_level_count;
    logic [LAYER_BITS-1:0] cutter_base_layer;
    logic [LAYER_BITS:0]   cutter_layer_count;
    logic [MIP_BITS-1:0]   cutter_base_mip;
    logic [MIP_BITS:0]     cutter_level_count;
  } req_t;

  typedef struct packed {
    logic [ASPECT_W-1:0] piece_aspect;
    logic [LAYER_BITS:0] piece_base_layer;
    logic [LAYER_BITS:0] piece_layer_count;
    logic [MIP_BITS:0]   piece_base_mip;
    logic [MIP_BITS:0]   piece_level_count;
    logic [PNUM_W-1:0]   piece_number;
    logic                last_piece;
  } piece_t;

  // up to three spans of one axis, packed to the front
  typedef struct packed {
    logic [1:0]                n;
    logic [2:0][SUM_W-1:0]     base;
    logic [2:0][CNT_W-1:0]     cnt;
  } span_set_t;

  // classified request as handed from front to back
  typedef struct packed {
    logic [ASPECT_W-1:0]         aspect;
    logic [1:0]                  lay_n;
    logic [2:0][LAYER_BITS:0]    lay_base;
    logic [2:0][LAYER_BITS:0]    lay_cnt;
    logic [2:0]                  lay_in;
    logic [1:0]                  mip_n;
    logic [2:0][MIP_BITS:0]      mip_base;
    logic [2:0][MIP_BITS:0]      mip_cnt;
    logic [MIP_BITS:0]           tgt_mip_base;
    logic [MIP_BITS:0]           tgt_mip_cnt;
  } plan_t;

  typedef struct packed {
    logic full;
    logic has_data;
  } q_stat_t;

  // cut span [base, base+cnt) at both cutter edges, clamped into the span;
  // order: part before cutter, part after it, part inside it
  function automatic span_set_t cut_axis(input logic [CW-1:0]    base,
                                         input logic [CNT_W-1:0] cnt,
                                         input logic [CW-1:0]    cbase,
                                         input logic [CNT_W-1:0] ccnt);
    span_set_t               r;
    logic signed [DIF_W-1:0] dlo;
    logic signed [DIF_W-1:0] dhi;
    logic [CNT_W-1:0]        lo;
    logic [CNT_W-1:0]        hi;
    logic [1:0]              n;
    r   = '0;
    n   = '0;
    dlo = $signed({3'b000, cbase}) - $signed({3'b000, base});
    dhi = $signed({3'b000, cbase}) + $signed({2'b00, ccnt}) - $signed({3'b000, base});
    if (dlo[DIF_W-1]) begin
      lo = '0;
    end else if (dlo > $signed({2'b00, cnt})) begin
      lo = cnt;
    end else begin
      lo = dlo[CNT_W-1:0];
    end
    if (dhi[DIF_W-1]) begin
      hi = '0;
    end else if (dhi > $signed({2'b00, cnt})) begin
      hi = cnt;
    end else begin
      hi = dhi[CNT_W-1:0];
    end
    if (lo != '0 && lo < cnt) begin
      r.base[n] = {2'b00, base};
      r.cnt[n]  = lo;
      n         = n + 2'd1;
    end
    if (hi != '0 && hi < cnt) begin
      r.base[n] = {2'b00, base} + {1'b0, hi};
      r.cnt[n]  = cnt - hi;
      n         = n + 2'd1;
    end
    if (hi > lo) begin
      r.base[n] = {2'b00, base} + {1'b0, lo};
      r.cnt[n]  = hi - lo;
      n         = n + 2'd1;
    end
    if (n == 2'd0) begin
      r.base[0] = {2'b00, base};
      r.cnt[0]  = cnt;
      n         = 2'd1;
    end
    r.n = n;
    return r;
  endfunction

endpackage

[hw/rtl/ssplit_if.sv]
// valid/ready channel interfaces for requests and pieces
interface ssplit_req_if;
  import ssplit_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssplit_piece_if;
  import ssplit_pkg::*;

  logic   valid;
  logic   ready;
  piece_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/ssplit_front.sv]
// front end: accepts a request and cuts both axes into a piece plan
module ssplit_front (
  ssplit_req_if.sink         in_req,
  input  ssplit_pkg::q_stat_t stat,
  output logic               push,
  output ssplit_pkg::plan_t  plan
);
  import ssplit_pkg::*;

  span_set_t        lay_set;
  span_set_t        mip_set;
  logic [CW-1:0]    cbl_w;
  logic [CNT_W-1:0] clc_w;
  logic [END_W-1:0] cut_end;
  logic [END_W-1:0] span_end;

  // accept whenever the queue has room
  assign in_req.ready = !stat.full;
  assign push         = in_req.valid && !stat.full;

  assign cbl_w = CW'(in_req.data.cutter_base_layer);
  assign clc_w = CNT_W'(in_req.data.cutter_layer_count);

  // cut both axes
  always_comb begin
    lay_set = cut_axis(CW'(in_req.data.target_base_layer),
                       CNT_W'(in_req.data.target_layer_count),
                       cbl_w, clc_w);
    mip_set = cut_axis(CW'(in_req.data.target_base_mip),
                       CNT_W'(in_req.data.target_level_count),
                       CW'(in_req.data.cutter_base_mip),
                       CNT_W'(in_req.data.cutter_level_count));
  end

  assign cut_end = END_W'(cbl_w) + END_W'(clc_w);

  // build plan, marking layer spans that sit wholly inside the cutter
  always_comb begin
    plan              = '0;
    span_end          = '0;
    plan.aspect       = in_req.data.target_aspect;
    plan.lay_n        = lay_set.n;
    plan.mip_n        = mip_set.n;
    plan.tgt_mip_base = (MIP_BITS + 1)'(in_req.data.target_base_mip);
    plan.tgt_mip_cnt  = in_req.data.target_level_count;
    for (int s = 0; s < 3; s++) begin
      span_end         = END_W'(lay_set.base[s]) + END_W'(lay_set.cnt[s]);
      plan.lay_base[s] = lay_set.base[s][LAYER_BITS:0];
      plan.lay_cnt[s]  = lay_set.cnt[s][LAYER_BITS:0];
      plan.lay_in[s]   = (END_W'(lay_set.base[s]) >= END_W'(cbl_w)) && (span_end <= cut_end);
      plan.mip_base[s] = mip_set.base[s][MIP_BITS:0];
      plan.mip_cnt[s]  = mip_set.cnt[s][MIP_BITS:0];
    end
  end

endmodule

[hw/rtl/ssplit_fifo.sv]
// short plan queue that decouples the front end from the piece sequencer
module ssplit_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ssplit_pkg::plan_t   wr_plan,
  input  logic                pop,
  output ssplit_pkg::plan_t   head,
  output ssplit_pkg::q_stat_t stat
);
  import ssplit_pkg::*;

  plan_t             entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QPTR_W:0]   count_nxt;

  assign stat.full     = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign stat.has_data = (count_r != '0);
  assign head          = entries_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wr_plan;
    end
  end

endmodule

[hw/rtl/ssplit_back.sv]
// back end: walks the plan at the queue head, one piece per cycle unless the output stalls
module ssplit_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ssplit_pkg::plan_t   head,
  input  ssplit_pkg::q_stat_t stat,
  output logic                pop,
  ssplit_piece_if.source      out_piece
);
  import ssplit_pkg::*;

  logic [1:0]        lay_idx_r;
  logic [1:0]        mip_idx_r;
  logic [PNUM_W-1:0] num_r;
  logic              valid_r;
  piece_t            piece_r;
  piece_t            piece_nxt;
  logic              in_cut;
  logic              mip_last;
  logic              lay_last;
  logic              span_done;
  logic              last;
  logic              advance;

  // position within the current plan
  always_comb begin
    in_cut    = head.lay_in[lay_idx_r];
    mip_last  = (mip_idx_r == head.mip_n - 2'd1);
    lay_last  = (lay_idx_r == head.lay_n - 2'd1);
    span_done = !in_cut || mip_last;
    last      = lay_last && span_done;
    advance   = stat.has_data && (!valid_r || out_piece.ready);
    pop       = advance && last;
  end

  // next piece
  always_comb begin
    piece_nxt.piece_aspect      = head.aspect;
    piece_nxt.piece_base_layer  = head.lay_base[lay_idx_r];
    piece_nxt.piece_layer_count = head.lay_cnt[lay_idx_r];
    piece_nxt.piece_base_mip    = in_cut ? head.mip_base[mip_idx_r] : head.tgt_mip_base;
    piece_nxt.piece_level_count = in_cut ? head.mip_cnt[mip_idx_r] : head.tgt_mip_cnt;
    piece_nxt.piece_number      = num_r;
    piece_nxt.last_piece        = last;
  end

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lay_idx_r <= '0;
      mip_idx_r <= '0;
      num_r     <= '0;
      valid_r   <= 1'b0;
    end else if (advance) begin
      valid_r <= 1'b1;
      if (last) begin
        lay_idx_r <= '0;
        mip_idx_r <= '0;
        num_r     <= '0;
      end else begin
        num_r <= num_r + 1'b1;
        if (span_done) begin
          lay_idx_r <= lay_idx_r + 2'd1;
          mip_idx_r <= '0;
        end else begin
          mip_idx_r <= mip_idx_r + 2'd1;
        end
      end
    end else if (out_piece.ready) begin
      valid_r <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (advance) begin
      piece_r <= piece_nxt;
    end
  end

  assign out_piece.valid = valid_r;
  assign out_piece.data  = piece_r;

endmodule

[hw/rtl/subresource_range_splitter_top.sv]
// Subresource range splitter: each request (target and cutter rectangles of
// array layers by mip levels, plus an aspect mask) yields one to five pieces,
// numbered from zero with the final one flagged by last_piece. The front end
// cuts both axes as a request is accepted and parks the result in a two-entry
// queue; the back end emits one piece per cycle from the queue head, while the
// piece channel does not stall, through an output register. Requests are
// accepted back to back while the queue has room, independent of stalls on the
// piece channel.
module subresource_range_splitter_top (
  input  logic           clk,
  input  logic           rst_n,
  ssplit_req_if.sink     in_req,
  ssplit_piece_if.source out_piece
);
  import ssplit_pkg::*;

`include "subresource_range_splitter_top_macros.svh"

  plan_t   wr_plan;
  plan_t   head;
  q_stat_t stat;
  logic    push;
  logic    pop;

  // request classification
  ssplit_front u_front (
    .in_req (in_req),
    .stat   (stat),
    .push   (push),
    .plan   (wr_plan)
  );

  // plan queue
  ssplit_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_plan (wr_plan),
    .pop     (pop),
    .head    (head),
    .stat    (stat)
  );

  // piece sequencer
  ssplit_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_piece (out_piece)
  );

  // checks
  `SSPLIT_ASSERT_IMPLY(a_num_range, clk, rst_n, out_piece.valid, out_piece.data.piece_number <= LAST_NUM)
  `SSPLIT_ASSERT_IMPLY(a_fifth_last, clk, rst_n, out_piece.valid && out_piece.data.piece_number == LAST_NUM, out_piece.data.last_piece)
  `SSPLIT_ASSERT_NEXT(a_run_continues, clk, rst_n, out_piece.valid && out_piece.ready && !out_piece.data.last_piece, out_piece.valid)
  `SSPLIT_ASSERT_IMPLY(a_pop_has_data, clk, rst_n, pop, stat.has_data)

endmodule
